[rtl/atws_pkg.sv]
`default_nettype none
package atws_pkg;

  localparam int SLOTS_DEF = 8;
  localparam int SLOT_W = 4;
  localparam int CNT_W = 5;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [7:0] RESET_INTERVAL = 8'd10;
  localparam logic [3:0] RESET_LIMIT = 4'd4;

  // Bit of the repeat word that marks a weekly alarm.
  localparam int WEEKLY_BIT = 7;
  localparam logic [2:0] LAST_DAY = 3'd6;

  localparam logic [ADDR_W-1:0] REG_INTERVAL = 3'd0;
  localparam logic [ADDR_W-1:0] REG_LIMIT = 3'd4;

  typedef enum logic [1:0] {
    OP_TICK,
    OP_WRITE,
    OP_READ
  } op_t;

  // One request as it walks down the row of slot cells.
  typedef struct packed {
    logic              valid;
    op_t               op;
    logic [SLOT_W-1:0] slot;
    logic [2:0]        day;
    logic [4:0]        hour;
    logic [5:0]        minute;
    logic [7:0]        w_repeat;
    logic [4:0]        w_hour;
    logic [5:0]        w_minute;
    logic              w_snooze;
    logic              w_enable;
    logic              found;
    logic [SLOT_W-1:0] ring_idx;
    logic [7:0]        r_repeat;
    logic [4:0]        r_hour;
    logic [5:0]        r_minute;
    logic              r_snooze;
    logic              r_enable;
    logic [CNT_W-1:0]  count;
  } req_t;

endpackage
`default_nettype wire

[rtl/alarm_table_with_snooze.sv]
// Weekly alarm table with snooze. A request (tick, slot write or slot read) is
// taken when start is high and busy is low. It passes a launch register, then
// walks down a row of SLOTS slot cells, one cell per clock, and a final register
// settles the snooze state, so the result appears on the result ports with done
// high for a single cycle. busy stays high until the request leaves the last
// cell, so a new request is taken only once the last one is through. The result
// is not held: the receiver must take it in the cycle that done is high.
`default_nettype none
module alarm_table_with_snooze
  import atws_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                start,
  output logic               busy,
  input  wire  [1:0]         opcode,
  input  wire  [3:0]         slot,
  input  wire  [2:0]         day_of_week,
  input  wire  [4:0]         now_hour,
  input  wire  [5:0]         now_minute,
  input  wire  [7:0]         entry_repeat_mask,
  input  wire  [4:0]         entry_hour,
  input  wire  [5:0]         entry_minute,
  input  wire                entry_snooze_flag,
  input  wire                entry_enable,
  output logic               done,
  output logic               ring,
  output logic [3:0]         ringing_slot,
  output logic [7:0]         read_repeat_mask,
  output logic [4:0]         read_hour,
  output logic [5:0]         read_minute,
  output logic               read_snooze_flag,
  output logic               read_enable,
  output logic [4:0]         valid_count,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire  [ADDR_W-1:0]  paddr,
  input  wire  [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  logic             accept;
  req_t             launch;
  req_t             chain [SLOTS+1];
  req_t             fin;
  logic [SLOTS:0]   in_flight;

  logic [7:0]       snooze_interval;
  logic [3:0]       snooze_limit;

  logic             snooze_active;
  logic [7:0]       snooze_ticks;
  logic [4:0]       snooze_rings;
  logic [3:0]       last_ring_slot;
  logic             snooze_active_next;
  logic [7:0]       snooze_ticks_next;
  logic [4:0]       snooze_rings_next;
  logic [3:0]       last_ring_slot_next;
  logic             ring_next;
  logic [7:0]       ticks_inc;
  logic [4:0]       rings_inc;

  assign accept = start && !busy;
  assign pready = 1'b1;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      snooze_interval <= RESET_INTERVAL;
      snooze_limit <= RESET_LIMIT;
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr)
        REG_INTERVAL: snooze_interval <= pwdata[7:0];
        REG_LIMIT:    snooze_limit <= pwdata[3:0];
        default:      ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_INTERVAL: prdata = {{(DATA_W-8){1'b0}}, snooze_interval};
      REG_LIMIT:    prdata = {{(DATA_W-4){1'b0}}, snooze_limit};
      default:      prdata = '0;
    endcase
  end

  // Request launch: slots at or beyond SLOTS fold onto slot 0.
  always_ff @(posedge clk) begin
    launch.op <= op_t'(opcode);
    launch.slot <= ({1'b0, slot} < 5'(SLOTS)) ? slot : '0;
    launch.day <= day_of_week;
    launch.hour <= now_hour;
    launch.minute <= now_minute;
    launch.w_repeat <= entry_repeat_mask;
    launch.w_hour <= entry_hour;
    launch.w_minute <= entry_minute;
    launch.w_snooze <= entry_snooze_flag;
    launch.w_enable <= entry_enable;
    launch.found <= 1'b0;
    launch.ring_idx <= '0;
    launch.r_repeat <= '0;
    launch.r_hour <= '0;
    launch.r_minute <= '0;
    launch.r_snooze <= 1'b0;
    launch.r_enable <= 1'b0;
    launch.count <= '0;
    if (rst) begin
      launch.valid <= 1'b0;
    end else begin
      launch.valid <= accept;
    end
  end

  assign chain[0] = launch;

  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    atws_cell #(
      .IDX(g)
    ) u_cell (
      .clk    (clk),
      .rst    (rst),
      .req_in (chain[g]),
      .req_out(chain[g+1])
    );
  end

  always_comb begin
    for (int i = 0; i <= SLOTS; i++) begin
      in_flight[i] = chain[i].valid;
    end
  end

  assign fin = chain[SLOTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (fin.valid) begin
      busy <= 1'b0;
    end
  end

  // Snooze bookkeeping once the request has seen every slot.
  always_comb begin
    ticks_inc = snooze_ticks + 8'd1;
    rings_inc = snooze_rings + 5'd1;
    snooze_active_next = snooze_active;
    snooze_ticks_next = snooze_ticks;
    snooze_rings_next = snooze_rings;
    last_ring_slot_next = last_ring_slot;
    ring_next = 1'b0;
    case (fin.op)
      OP_TICK: begin
        if (fin.found) begin
          snooze_active_next = 1'b1;
          snooze_ticks_next = '0;
          snooze_rings_next = '0;
          last_ring_slot_next = fin.ring_idx;
          ring_next = 1'b1;
        end else if (snooze_active) begin
          snooze_ticks_next = ticks_inc;
          if (ticks_inc == snooze_interval) begin
            snooze_rings_next = rings_inc;
            if (rings_inc > {1'b0, snooze_limit}) begin
              snooze_active_next = 1'b0;
            end else begin
              snooze_ticks_next = '0;
              ring_next = 1'b1;
            end
          end
        end
      end
      OP_WRITE: begin
        // Disabling the slot that rang last also silences its snooze.
        if ((last_ring_slot == fin.slot) && !fin.w_enable) begin
          snooze_active_next = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      snooze_active <= 1'b0;
      snooze_ticks <= '0;
      snooze_rings <= '0;
      last_ring_slot <= '0;
      done <= 1'b0;
    end else begin
      done <= fin.valid;
      if (fin.valid) begin
        snooze_active <= snooze_active_next;
        snooze_ticks <= snooze_ticks_next;
        snooze_rings <= snooze_rings_next;
        last_ring_slot <= last_ring_slot_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fin.valid) begin
      ring <= ring_next;
      ringing_slot <= last_ring_slot_next;
      read_repeat_mask <= fin.r_repeat;
      read_hour <= fin.r_hour;
      read_minute <= fin.r_minute;
      read_snooze_flag <= fin.r_snooze;
      read_enable <= fin.r_enable;
      valid_count <= fin.count;
    end
  end

  a_one_in_flight : assert property (@(posedge clk) disable iff (rst)
    $onehot0(in_flight))
    else $error("more than one request in the slot row");

  a_idle_empty : assert property (@(posedge clk) disable iff (rst)
    !busy |-> (in_flight == '0))
    else $error("request in the slot row while not busy");

  a_done_idle : assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && !$past(accept))
    else $error("result strobe while a request is still in progress");

  a_ring_slot : assert property (@(posedge clk) disable iff (rst)
    (done && ring && $past(fin.found)) |-> ({1'b0, ringing_slot} < 5'(SLOTS)))
    else $error("ringing slot outside the table");

endmodule
`default_nettype wire

[rtl/atws_cell.sv]
`default_nettype none
module atws_cell
  import atws_pkg::*;
#(
  parameter int IDX = 0
) (
  input  wire  clk,
  input  wire  rst,
  input  req_t req_in,
  output req_t req_out
);

  logic [7:0] repeat_word;
  logic [4:0] hour;
  logic [5:0] minute;
  logic       snooze;
  logic       enable;

  logic [7:0] repeat_next;
  logic [4:0] hour_next;
  logic [5:0] minute_next;
  logic       snooze_next;
  logic       enable_next;

  logic       sel;
  logic       day_hit;
  logic       match;
  req_t       req_next;

  always_comb begin
    sel = req_in.valid && (req_in.slot == SLOT_W'(IDX));
    day_hit = (req_in.day <= LAST_DAY) && repeat_word[req_in.day];
    // A single-shot alarm ignores the weekday.
    match = req_in.valid && (req_in.op == OP_TICK) && !req_in.found && enable &&
            (hour == req_in.hour) && (minute == req_in.minute) &&
            (repeat_word[WEEKLY_BIT] ? day_hit : 1'b1);

    repeat_next = repeat_word;
    hour_next = hour;
    minute_next = minute;
    snooze_next = snooze;
    enable_next = enable;
    if (sel && (req_in.op == OP_WRITE)) begin
      repeat_next = req_in.w_repeat;
      hour_next = req_in.w_hour;
      minute_next = req_in.w_minute;
      snooze_next = req_in.w_snooze;
      enable_next = req_in.w_enable;
    end
    if (match && !repeat_word[WEEKLY_BIT]) begin
      enable_next = 1'b0;
    end

    req_next = req_in;
    if (match) begin
      req_next.found = 1'b1;
      req_next.ring_idx = SLOT_W'(IDX);
    end
    if (sel && (req_in.op == OP_READ)) begin
      req_next.r_repeat = repeat_word;
      req_next.r_hour = hour;
      req_next.r_minute = minute;
      req_next.r_snooze = snooze;
      req_next.r_enable = enable;
    end
    req_next.count = req_in.count +
                     CNT_W'(|{repeat_next, enable_next, hour_next, minute_next});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      repeat_word <= '0;
      hour <= '0;
      minute <= '0;
      snooze <= 1'b0;
      enable <= 1'b0;
    end else begin
      repeat_word <= repeat_next;
      hour <= hour_next;
      minute <= minute_next;
      snooze <= snooze_next;
      enable <= enable_next;
    end
  end

  always_ff @(posedge clk) begin
    req_out <= req_next;
    if (rst) begin
      req_out.valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

[test/atws_checker.sv]
module atws_checker
  import atws_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEF
) (
  input  wire               clk,
  input  wire               rst,
  input  wire               start,
  input  wire               busy,
  input  wire  [1:0]        opcode,
  input  wire  [3:0]        slot,
  input  wire  [2:0]        day_of_week,
  input  wire  [4:0]        now_hour,
  input  wire  [5:0]        now_minute,
  input  wire  [7:0]        entry_repeat_mask,
  input  wire  [4:0]        entry_hour,
  input  wire  [5:0]        entry_minute,
  input  wire               entry_snooze_flag,
  input  wire               entry_enable,
  input  wire               done,
  input  wire               ring,
  input  wire  [3:0]        ringing_slot,
  input  wire  [7:0]        read_repeat_mask,
  input  wire  [4:0]        read_hour,
  input  wire  [5:0]        read_minute,
  input  wire               read_snooze_flag,
  input  wire               read_enable,
  input  wire  [4:0]        valid_count,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire               pready,
  input  wire  [ADDR_W-1:0] paddr,
  input  wire  [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                waiting,
  output int                rings_seen,
  output int                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic       ring;
    logic [3:0] ring_slot;
    logic [7:0] rd_repeat;
    logic [4:0] rd_hour;
    logic [5:0] rd_minute;
    logic       rd_snooze;
    logic       rd_enable;
    logic [4:0] used_slots;
  } alarm_result_t;

  logic [7:0] tbl_repeat [SLOTS];
  logic [4:0] tbl_hour [SLOTS];
  logic [5:0] tbl_minute [SLOTS];
  logic       tbl_snooze [SLOTS];
  logic       tbl_enable [SLOTS];
  logic       snooze_on;
  logic [7:0] snooze_cnt;
  logic [4:0] snooze_rerings;
  logic [3:0] ring_slot_q;
  logic [7:0] cfg_interval;
  logic [3:0] cfg_limit;

  alarm_result_t expected_results [$];
  int fails = 0;
  int results_n = 0;
  int rings_n = 0;

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fails++;
      if (fails <= 10)
        $display("%0t: result %0d, %s mismatch: expected %0h, got %0h",
                 $time, results_n, name, want, got);
    end
  endtask

  task automatic predict_request(input logic [1:0] op, input logic [3:0] s_in,
                                 input logic [2:0] day, input logic [4:0] hr,
                                 input logic [5:0] mn, input logic [7:0] w_rep,
                                 input logic [4:0] w_hr, input logic [5:0] w_mn,
                                 input logic w_snz, input logic w_en,
                                 output alarm_result_t res);
    int  s;
    bit  hit;
    bit  match;
    int  used;
    s = (s_in < SLOTS) ? int'(s_in) : 0;
    res = '0;
    hit = 1'b0;
    used = 0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!hit && tbl_enable[i] && tbl_hour[i] == hr && tbl_minute[i] == mn) begin
            // Weekly slots need the weekday bit; single-shot ones ignore the day.
            match = tbl_repeat[i][WEEKLY_BIT] ? (day <= LAST_DAY && tbl_repeat[i][day])
                                              : 1'b1;
            if (match) begin
              hit = 1'b1;
              if (!tbl_repeat[i][WEEKLY_BIT])
                tbl_enable[i] = 1'b0;
              snooze_on = 1'b1;
              snooze_cnt = '0;
              snooze_rerings = '0;
              ring_slot_q = 4'(i);
            end
          end
        end
        if (hit) begin
          res.ring = 1'b1;
        end else if (snooze_on) begin
          snooze_cnt = snooze_cnt + 8'd1;
          if (snooze_cnt == cfg_interval) begin
            snooze_rerings = snooze_rerings + 5'd1;
            if (snooze_rerings > {1'b0, cfg_limit}) begin
              snooze_on = 1'b0;
            end else begin
              snooze_cnt = '0;
              res.ring = 1'b1;
            end
          end
        end
      end
      OP_WRITE: begin
        tbl_repeat[s] = w_rep;
        tbl_hour[s] = w_hr;
        tbl_minute[s] = w_mn;
        tbl_snooze[s] = w_snz;
        tbl_enable[s] = w_en;
        if (ring_slot_q == 4'(s) && !w_en)
          snooze_on = 1'b0;
      end
      OP_READ: begin
        res.rd_repeat = tbl_repeat[s];
        res.rd_hour = tbl_hour[s];
        res.rd_minute = tbl_minute[s];
        res.rd_snooze = tbl_snooze[s];
        res.rd_enable = tbl_enable[s];
      end
      default: ;
    endcase
    for (int i = 0; i < SLOTS; i++)
      if (tbl_repeat[i] != 0 || tbl_enable[i] || tbl_hour[i] != 0 || tbl_minute[i] != 0)
        used++;
    res.ring_slot = ring_slot_q;
    res.used_slots = 5'(used);
  endtask

  always @(posedge clk) begin : monitor
    alarm_result_t got;
    alarm_result_t want;
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        tbl_repeat[i] = '0;
        tbl_hour[i] = '0;
        tbl_minute[i] = '0;
        tbl_snooze[i] = 1'b0;
        tbl_enable[i] = 1'b0;
      end
      snooze_on = 1'b0;
      snooze_cnt = '0;
      snooze_rerings = '0;
      ring_slot_q = '0;
      cfg_interval = RESET_INTERVAL;
      cfg_limit = RESET_LIMIT;
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == REG_INTERVAL)
          cfg_interval = pwdata[7:0];
        else if (paddr == REG_LIMIT)
          cfg_limit = pwdata[3:0];
      end
      // Retire the finished request before queuing one taken at this same edge.
      if (done) begin
        got = {ring, ringing_slot, read_repeat_mask, read_hour, read_minute,
               read_snooze_flag, read_enable, valid_count};
        if (expected_results.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result with no request outstanding", $time);
        end else begin
          want = expected_results.pop_front();
          check_field("ring", 8'(want.ring), 8'(got.ring));
          check_field("ringing_slot", 8'(want.ring_slot), 8'(got.ring_slot));
          check_field("read_repeat_mask", want.rd_repeat, got.rd_repeat);
          check_field("read_hour", 8'(want.rd_hour), 8'(got.rd_hour));
          check_field("read_minute", 8'(want.rd_minute), 8'(got.rd_minute));
          check_field("read_snooze_flag", 8'(want.rd_snooze), 8'(got.rd_snooze));
          check_field("read_enable", 8'(want.rd_enable), 8'(got.rd_enable));
          check_field("valid_count", 8'(want.used_slots), 8'(got.used_slots));
          if (want.ring)
            rings_n++;
        end
        results_n++;
      end
      if (start && !busy) begin
        predict_request(opcode, slot, day_of_week, now_hour, now_minute,
                        entry_repeat_mask, entry_hour, entry_minute,
                        entry_snooze_flag, entry_enable, want);
        expected_results.push_back(want);
      end
    end
    fail_count <= fails;
    waiting <= expected_results.size();
    rings_seen <= rings_n;
    results_seen <= results_n;
  end

endmodule

[test/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import atws_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int SETTLE = SLOTS + 4;
  localparam int PHASES = 5;
  localparam int PHASE_REQUESTS = 55;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic [1:0]        opcode = '0;
  logic [3:0]        slot = '0;
  logic [2:0]        day_of_week = '0;
  logic [4:0]        now_hour = '0;
  logic [5:0]        now_minute = '0;
  logic [7:0]        entry_repeat_mask = '0;
  logic [4:0]        entry_hour = '0;
  logic [5:0]        entry_minute = '0;
  logic              entry_snooze_flag = 1'b0;
  logic              entry_enable = 1'b0;
  logic              done;
  logic              ring;
  logic [3:0]        ringing_slot;
  logic [7:0]        read_repeat_mask;
  logic [4:0]        read_hour;
  logic [5:0]        read_minute;
  logic              read_snooze_flag;
  logic              read_enable;
  logic [4:0]        valid_count;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  int                fail_count;
  int                waiting;
  int                rings_seen;
  int                results_seen;

  int         burst_left = 0;
  logic [4:0] pool_hour [3];
  logic [5:0] pool_minute [3];
  logic [7:0] phase_interval [PHASES] = '{8'd1, 8'd255, 8'd3, 8'd2, 8'd1};
  logic [3:0] phase_limit [PHASES] = '{4'd0, 4'd15, 4'd15, 4'd1, 4'd7};

  alarm_table_with_snooze #(.SLOTS(SLOTS)) dut (.*);
  atws_checker #(.SLOTS(SLOTS)) u_checker (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  initial begin
    #5_000_000;
    $display("FAIL alarm_table_with_snooze");
    $finish;
  end

  // Called at a rising edge; returns at the edge that took the request, or
  // after the idle gap that follows the end of a burst.
  task automatic send(input logic [1:0] op, input logic [3:0] s, input logic [2:0] d,
                      input logic [4:0] h, input logic [5:0] m, input logic [7:0] rep,
                      input logic [4:0] eh, input logic [5:0] em, input logic esnz,
                      input logic een);
    int gap;
    start <= 1'b1;
    opcode <= op;
    slot <= s;
    day_of_week <= d;
    now_hour <= h;
    now_minute <= m;
    entry_repeat_mask <= rep;
    entry_hour <= eh;
    entry_minute <= em;
    entry_snooze_flag <= esnz;
    entry_enable <= een;
    // busy only moves on a rising edge, so its value mid-cycle is what the next edge sees.
    do @(negedge clk); while (busy);
    @(posedge clk);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(3) == 0) ? 40 : $urandom_range(8);
      gap = ($urandom_range(4) == 0) ? $urandom_range(40) : $urandom_range(12);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic tick(input logic [2:0] d, input logic [4:0] h, input logic [5:0] m);
    send(OP_TICK, 4'd0, d, h, m, 8'd0, 5'd0, 6'd0, 1'b0, 1'b0);
  endtask

  task automatic write_slot(input logic [3:0] s, input logic [7:0] rep, input logic [4:0] h,
                            input logic [5:0] m, input logic snz, input logic en);
    send(OP_WRITE, s, 3'd0, 5'd0, 6'd0, rep, h, m, snz, en);
  endtask

  task automatic read_slot(input logic [3:0] s);
    send(OP_READ, s, 3'd0, 5'd0, 6'd0, 8'd0, 5'd0, 6'd0, 1'b0, 1'b0);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (waiting != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Ticks and writes mostly share a few alarm times so that slots actually match.
  task automatic random_request();
    int         r;
    logic [1:0] op;
    logic [4:0] h;
    logic [4:0] eh;
    logic [5:0] m;
    logic [5:0] em;
    logic [7:0] rep;
    r = $urandom_range(99);
    if (r < 55)
      op = OP_TICK;
    else if (r < 80)
      op = OP_WRITE;
    else if (r < 96)
      op = OP_READ;
    else
      op = OP_UNUSED;
    r = $urandom_range(2);
    h = pool_hour[r];
    m = pool_minute[r];
    if ($urandom_range(4) == 0) begin
      h = 5'($urandom);
      m = 6'($urandom);
    end
    r = $urandom_range(2);
    eh = pool_hour[r];
    em = pool_minute[r];
    if ($urandom_range(6) == 0) begin
      eh = 5'($urandom);
      em = 6'($urandom);
    end
    case ($urandom_range(3))
      0: rep = 8'h00;
      1: rep = 8'($urandom);
      default: rep = {1'b1, 7'($urandom)};
    endcase
    send(op, ($urandom_range(4) == 0) ? 4'($urandom) : 4'($urandom_range(SLOTS - 1)),
         3'($urandom_range(7)), h, m, rep, eh, em, 1'($urandom), $urandom_range(4) != 0);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    read_slot(4'd0);
    // Disabling slot 0 right after reset hits the ringing-slot rule with snooze idle.
    write_slot(4'd0, 8'h00, 5'd0, 6'd0, 1'b0, 1'b0);
    send(OP_UNUSED, 4'hf, 3'd7, 5'h1f, 6'h3f, 8'hff, 5'h1f, 6'h3f, 1'b1, 1'b1);
    write_slot(4'd7, 8'hff, 5'd31, 6'd63, 1'b1, 1'b1);
    read_slot(4'd7);
    write_slot(4'd12, 8'h81, 5'd6, 6'd30, 1'b0, 1'b1);
    read_slot(4'd15);
    tick(3'd7, 5'd6, 6'd30);
    tick(3'd0, 5'd6, 6'd30);
    write_slot(4'd3, 8'h00, 5'd7, 6'd15, 1'b0, 1'b1);
    tick(3'd7, 5'd7, 6'd15);
    read_slot(4'd3);
    write_slot(4'd5, 8'h00, 5'd0, 6'd0, 1'b1, 1'b0);
    repeat (10) tick(3'd2, 5'd7, 6'd15);
    write_slot(4'd3, 8'h00, 5'd7, 6'd15, 1'b0, 1'b0);
    tick(3'd6, 5'd31, 6'd63);

    // With a zero interval the 8-bit tick count has to wrap before a re-ring.
    wait_idle();
    apb_write(REG_INTERVAL, 32'd0);
    apb_write(REG_LIMIT, 32'd1);
    for (int i = 0; i < SLOTS; i++)
      write_slot(4'(i), 8'h00, 5'd0, 6'd0, 1'b0, 1'b0);
    write_slot(4'd2, 8'h00, 5'd12, 6'd0, 1'b1, 1'b1);
    tick(3'd3, 5'd12, 6'd0);
    repeat (260) tick(3'($urandom_range(7)), 5'd13, 6'd0);

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      apb_write(REG_INTERVAL, 32'(phase_interval[p]));
      apb_write(REG_LIMIT, 32'(phase_limit[p]));
      for (int i = 0; i < 3; i++) begin
        pool_hour[i] = 5'($urandom_range(23));
        pool_minute[i] = 6'($urandom_range(59));
      end
      repeat (PHASE_REQUESTS) random_request();
    end

    wait_idle();
    $display("Checked %0d requests, %0d of which rang, over the reset, zero-interval",
             results_seen, rings_seen);
    $display("and %0d random snooze settings with bursty request traffic.", PHASES);
    if (fail_count == 0 && waiting == 0)
      $display("PASS alarm_table_with_snooze");
    else
      $display("FAIL alarm_table_with_snooze");
    $finish;
  end

endmodule
